### design/p2bm_pkg.sv
// ----------------------------------------------------------------------------
// p2bm_pkg
// Shared widths, register indexes and defaults for the 2x2 block mean.
// ----------------------------------------------------------------------------
package p2bm_pkg;

   localparam int PIX_W     = 8;   // input pixel and block mean
   localparam int CFG_W     = 9;   // configuration register data
   localparam int OUT_W     = 9;   // output row and column tags
   localparam int SUM_W     = 9;   // pair sum of two pixels
   localparam int CSR_IDX_W = 2;

   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;

   localparam logic [CFG_W-1:0] HALF_RESET = 9'd256;

   localparam logic [CSR_IDX_W-1:0] REG_HALF_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_HEIGHT = 2'd1;

   localparam logic [1:0] BEAT_FIRST = 2'd0;
   localparam logic [1:0] BEAT_LAST  = 2'd3;

endpackage

### design/pixelate_2x2_block_mean.sv
// ----------------------------------------------------------------------------
// pixelate_2x2_block_mean
// 2x2 box average of an 8-bit grayscale raster stream, four results per block.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per cycle while req_ready is high.
// Even rows and the first pixel of each pair on odd rows finish in the cycle
// they are accepted. The second pixel of a pair on an odd row finishes a
// block and loads the result register, which drains its four transactions
// (upper left, upper right, lower left, lower right) at one per cycle while
// rsp_ready is high; a further block can enter only as that drain ends. The
// pair-sum line buffer needs no clearing after reset. A write to either size
// register restarts the frame.
module pixelate_2x2_block_mean #(
   parameter int MAX_WIDTH  = p2bm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = p2bm_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [p2bm_pkg::PIX_W-1:0]     req_pixel,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [p2bm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [p2bm_pkg::CFG_W-1:0]     csr_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [p2bm_pkg::OUT_W-1:0]     rsp_out_row,
   output logic [p2bm_pkg::OUT_W-1:0]     rsp_out_col,
   output logic [p2bm_pkg::PIX_W-1:0]     rsp_value,
   output logic                           rsp_block_last,
   output logic                           rsp_frame_last
);
   import p2bm_pkg::*;

   localparam int SLOTS  = MAX_WIDTH / 2;
   localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int RSLOTS = MAX_HEIGHT / 2;
   localparam int RW     = (RSLOTS > 1) ? $clog2(RSLOTS) : 1;

   logic [CFG_W-1:0] half_width_ff, half_width_in;
   logic [CFG_W-1:0] half_height_ff, half_height_in;
   logic [PIX_W-1:0] left_ff, left_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic             cphase_ff, cphase_in;
   logic [RW-1:0]    rblk_ff, rblk_in;
   logic             rphase_ff, rphase_in;

   logic             busy_ff, busy_in;
   logic [1:0]       beat_ff, beat_in;
   logic [PIX_W-1:0] mean_ff, mean_in;
   logic [SW-1:0]    bcol_ff, bcol_in;
   logic [RW-1:0]    brow_ff, brow_in;
   logic             flast_ff, flast_in;

   logic [SW-1:0]    hw_m1;
   logic [RW-1:0]    hh_m1;
   logic             accept, finish, drain, col_last, row_last, cfg_wr;
   logic [SUM_W-1:0] pair_rd, pair_wr;
   logic [SUM_W:0]   block_sum;

   // clamp registers to the buffer size; zero counts as one block
   always_comb begin
      if (half_width_ff == '0) begin
         hw_m1 = '0;
      end else if (int'(half_width_ff) > SLOTS) begin
         hw_m1 = SW'(SLOTS - 1);
      end else begin
         hw_m1 = SW'(int'(half_width_ff) - 1);
      end
      if (half_height_ff == '0) begin
         hh_m1 = '0;
      end else if (int'(half_height_ff) > RSLOTS) begin
         hh_m1 = RW'(RSLOTS - 1);
      end else begin
         hh_m1 = RW'(int'(half_height_ff) - 1);
      end
   end

   assign finish    = cphase_ff && rphase_ff;
   assign drain     = busy_ff && rsp_ready && (beat_ff == BEAT_LAST);
   assign req_ready = !finish || !busy_ff || drain;
   assign accept    = req_valid && req_ready;
   assign col_last  = cphase_ff && (slot_ff == hw_m1);
   assign row_last  = rphase_ff && (rblk_ff == hh_m1);
   assign csr_ready = 1'b1;
   assign cfg_wr    = csr_valid && csr_ready &&
                      (csr_index == REG_HALF_WIDTH || csr_index == REG_HALF_HEIGHT);

   assign pair_wr   = SUM_W'(left_ff) + SUM_W'(req_pixel);
   assign block_sum = (SUM_W + 1)'(pair_rd) + (SUM_W + 1)'(left_ff)
                      + (SUM_W + 1)'(req_pixel);

   p2bm_line_buf #(
      .SLOTS (SLOTS),
      .SW    (SW)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (accept && cphase_ff && !rphase_ff),
      .rd_en   (accept && !cphase_ff),
      .addr    (slot_ff),
      .wr_data (pair_wr),
      .rd_data (pair_rd)
   );

   // position counters and registers
   always_comb begin
      half_width_in  = half_width_ff;
      half_height_in = half_height_ff;
      left_in        = left_ff;
      slot_in        = slot_ff;
      cphase_in      = cphase_ff;
      rblk_in        = rblk_ff;
      rphase_in      = rphase_ff;
      if (cfg_wr) begin
         if (csr_index == REG_HALF_WIDTH) begin
            half_width_in = csr_data;
         end else begin
            half_height_in = csr_data;
         end
         left_in   = '0;
         slot_in   = '0;
         cphase_in = 1'b0;
         rblk_in   = '0;
         rphase_in = 1'b0;
      end else if (accept) begin
         if (!cphase_ff) begin
            left_in   = req_pixel;
            cphase_in = 1'b1;
         end else begin
            cphase_in = 1'b0;
            if (col_last) begin
               slot_in   = '0;
               rphase_in = !rphase_ff;
               if (row_last) begin
                  rblk_in = '0;
               end else if (rphase_ff) begin
                  rblk_in = rblk_ff + 1'b1;
               end
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
      end
   end

   // result register: load a finished block, then hand out four transactions
   always_comb begin
      busy_in  = busy_ff;
      beat_in  = beat_ff;
      mean_in  = mean_ff;
      bcol_in  = bcol_ff;
      brow_in  = brow_ff;
      flast_in = flast_ff;
      if (accept && finish) begin
         busy_in  = 1'b1;
         beat_in  = BEAT_FIRST;
         mean_in  = block_sum[SUM_W:2];
         bcol_in  = slot_ff;
         brow_in  = rblk_ff;
         flast_in = col_last && row_last;
      end else if (busy_ff && rsp_ready) begin
         if (beat_ff == BEAT_LAST) begin
            busy_in = 1'b0;
         end else begin
            beat_in = beat_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff  <= HALF_RESET;
         half_height_ff <= HALF_RESET;
         left_ff        <= '0;
         slot_ff        <= '0;
         cphase_ff      <= 1'b0;
         rblk_ff        <= '0;
         rphase_ff      <= 1'b0;
         busy_ff        <= 1'b0;
         beat_ff        <= BEAT_FIRST;
      end else begin
         half_width_ff  <= half_width_in;
         half_height_ff <= half_height_in;
         left_ff        <= left_in;
         slot_ff        <= slot_in;
         cphase_ff      <= cphase_in;
         rblk_ff        <= rblk_in;
         rphase_ff      <= rphase_in;
         busy_ff        <= busy_in;
         beat_ff        <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      mean_ff  <= mean_in;
      bcol_ff  <= bcol_in;
      brow_ff  <= brow_in;
      flast_ff <= flast_in;
   end

   assign rsp_valid      = busy_ff;
   assign rsp_out_row    = OUT_W'({brow_ff, beat_ff[1]});
   assign rsp_out_col    = OUT_W'({bcol_ff, beat_ff[0]});
   assign rsp_value      = mean_ff;
   assign rsp_block_last = (beat_ff == BEAT_LAST);
   assign rsp_frame_last = flast_ff && (beat_ff == BEAT_LAST);

   a_block_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && finish) |=> (rsp_valid && beat_ff == BEAT_FIRST))
      else $error("finished block did not start its result transactions");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !drain) |-> !(accept && finish))
      else $error("block accepted while result register still in use");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      (slot_ff <= hw_m1) && (rblk_ff <= hh_m1))
      else $error("position counter beyond configured image size");

   a_frame_end_wraps: assert property (@(posedge clock) disable iff (reset)
      (accept && finish && col_last && row_last && !cfg_wr)
      |=> (slot_ff == '0 && rblk_ff == '0 && !rphase_ff && !cphase_ff))
      else $error("counters did not wrap at frame end");

endmodule

### design/p2bm_line_buf.sv
// ----------------------------------------------------------------------------
// p2bm_line_buf
// Single-port line buffer of pair sums, one entry per 2x2 block column.
// ----------------------------------------------------------------------------
module p2bm_line_buf #(
   parameter int SLOTS = p2bm_pkg::DEF_MAX_WIDTH / 2,
   parameter int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic                       rd_en,
   input  logic [SW-1:0]              addr,
   input  logic [p2bm_pkg::SUM_W-1:0] wr_data,
   output logic [p2bm_pkg::SUM_W-1:0] rd_data
);
   import p2bm_pkg::*;

   logic [SUM_W-1:0] mem [SLOTS];
   logic [SUM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
